// ===== hdl/pose_pid_with_frame_rotation_defines.svh =====
// Assertion macros shared by the pose controller RTL.
// Included by the top level; depends on nothing else.
`ifndef POSE_PID_WITH_FRAME_ROTATION_DEFINES_SVH
`define POSE_PID_WITH_FRAME_ROTATION_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define PPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose controller assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define PPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose controller assertion failed");

`endif

// ===== hdl/ppr_pkg.sv =====
// Shared constants, command and status types for the pose controller.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

    // Number of CORDIC rotation steps and the count actually run.
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    // Restoring divider: a 49-bit dividend gives one quotient bit per step.
    localparam int DIV_STEPS = 49;

    // Microprogram lengths.
    localparam int MAC_STEPS = 10;
    localparam int ROT_STEPS = 7;

    // Angles in Q16.16.
    localparam logic signed [19:0] PI_Q      = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q  = 20'sd411775;
    localparam logic signed [19:0] HALF_PI_Q = 20'sd102944;

    // CORDIC gain start value in Q2.30.
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

    // Gain register reset value: kp = 1.0, ki = kd = 0.
    localparam logic [47:0] GAIN_RESET = 48'h1000_0000_0000;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAINS_X       = 2'd0;
    localparam logic [1:0] REG_GAINS_Y       = 2'd1;
    localparam logic [1:0] REG_GAINS_HEADING = 2'd2;

    // Multiplier operand pairs.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ERR_DT,
        MUL_KP,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_KD_LO,
        MUL_KD_HI,
        MUL_VX_C,
        MUL_VY_S,
        MUL_VY_C,
        MUL_VX_S
    } t_mul_sel;

    // Operations on the registered product.
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_INTEG,
        ACC_SUM_FIRST,
        ACC_PART_SET,
        ACC_PART_ADD_HI,
        ACC_SUM_NEXT,
        ACC_VEL_SET,
        ACC_PART_ADD,
        ACC_PART_SUB,
        ACC_FWD_SET,
        ACC_LAT_SET
    } t_acc_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_step;
        logic       div_end;
        logic       cordic_step;
        logic [4:0] cordic_idx;
        logic [1:0] axis;
        t_mul_sel   mul_sel;
        t_acc_op    acc_op;
        logic       out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dt_zero;
    } t_dp_status;

    // CORDIC arctangent table, Q16.16.
    function automatic logic [16:0] atan_entry(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ppr_dp.sv =====
// Datapath of the pose controller: errors, three-lane divider, CORDIC,
// shared multiplier with accumulators, gain registers and output registers.
// Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_dp
    import ppr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic signed [31:0]  i_current_x,
    input  logic signed [31:0]  i_current_y,
    input  logic signed [18:0]  i_current_heading,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [18:0]  i_target_heading,
    input  logic        [23:0]  i_time_step,
    input  logic                i_cfg_we,
    input  logic        [1:0]   i_cfg_index,
    input  logic        [47:0]  i_cfg_data,
    output logic signed [31:0]  o_vel_forward,
    output logic signed [31:0]  o_vel_lateral,
    output logic signed [31:0]  o_turn_rate
);

    localparam logic signed [65:0] Max32 = 66'sd2147483647;
    localparam logic signed [65:0] Min32 = -66'sd2147483648;
    localparam logic signed [65:0] Max48 = 66'sd140737488355327;
    localparam logic signed [65:0] Min48 = -66'sd140737488355328;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > Max32) r = 32'sh7fff_ffff;
        else if (v < Min32) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        logic signed [47:0] r;
        if (v > Max48) r = 48'sh7fff_ffff_ffff;
        else if (v < Min48) r = 48'sh8000_0000_0000;
        else r = v[47:0];
        return r;
    endfunction

    // Model state and configuration.
    logic        [47:0] r_gains [3];
    logic signed [31:0] r_last  [3];
    logic signed [47:0] r_accum [3];

    // Working registers.
    logic signed [31:0] r_err   [3];
    logic signed [47:0] r_deriv [3];
    logic signed [31:0] r_vel   [3];
    logic        [23:0] r_dt;
    logic signed [32:0] r_x, r_y;
    logic signed [19:0] r_z;
    logic               r_flip;
    logic signed [65:0] r_prod, r_part, r_sum;
    logic signed [31:0] r_fwd, r_lat;
    logic        [23:0] r_rem [3];
    logic        [48:0] r_quo [3];
    logic               r_neg [3];
    logic signed [31:0] r_o_fwd, r_o_lat, r_o_turn;

    // Item load: errors, heading wrap and CORDIC start angle.
    logic signed [32:0] n_dx, n_dy;
    logic signed [19:0] n_dh, n_eh, n_ch, n_cw, n_z0;
    logic               n_flip0;

    always_comb begin
        n_dx = 33'(i_target_x) - 33'(i_current_x);
        n_dy = 33'(i_target_y) - 33'(i_current_y);
        n_dh = 20'(i_target_heading) - 20'(i_current_heading);
        if (n_dh > PI_Q) n_eh = n_dh - TWO_PI_Q;
        else if (n_dh < -PI_Q) n_eh = n_dh + TWO_PI_Q;
        else n_eh = n_dh;
        n_ch = 20'(i_current_heading);
        if (n_ch > PI_Q) n_cw = n_ch - TWO_PI_Q;
        else if (n_ch < -PI_Q) n_cw = n_ch + TWO_PI_Q;
        else n_cw = n_ch;
        n_flip0 = 1'b1;
        if (n_cw > HALF_PI_Q) n_z0 = n_cw - PI_Q;
        else if (n_cw < -HALF_PI_Q) n_z0 = n_cw + PI_Q;
        else begin
            n_z0    = n_cw;
            n_flip0 = 1'b0;
        end
    end

    assign o_status.dt_zero = (r_dt == 24'd0);

    // Divider lanes: start values, one restoring step and the final result.
    logic signed [32:0] n_diff [3];
    logic        [32:0] n_mag  [3];
    logic        [24:0] n_rsh  [3];
    logic               n_qbit [3];
    logic signed [47:0] n_dres [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_diff[k] = 33'(r_err[k]) - 33'(r_last[k]);
            n_mag[k]  = n_diff[k][32] ? 33'(-n_diff[k]) : n_diff[k];
            n_rsh[k]  = {r_rem[k], r_quo[k][48]};
            n_qbit[k] = (n_rsh[k] >= {1'b0, r_dt});
            if (r_neg[k]) begin
                if (r_quo[k] >= 49'h0_8000_0000_0000) n_dres[k] = 48'sh8000_0000_0000;
                else n_dres[k] = 48'(-r_quo[k][47:0]);
            end else begin
                if (r_quo[k][48] || r_quo[k][47]) n_dres[k] = 48'sh7fff_ffff_ffff;
                else n_dres[k] = r_quo[k][47:0];
            end
        end
    end

    // CORDIC step and the signed cosine and sine after unfolding.
    logic signed [32:0] n_sx, n_sy, n_cos, n_sin;
    logic signed [19:0] n_atan;

    always_comb begin
        n_sx   = r_x >>> i_cmd.cordic_idx;
        n_sy   = r_y >>> i_cmd.cordic_idx;
        n_atan = 20'(atan_entry(i_cmd.cordic_idx));
        n_cos  = r_flip ? -r_x : r_x;
        n_sin  = r_flip ? -r_y : r_y;
    end

    // Multiplier operand selection.
    logic        [1:0]  n_ax;
    logic signed [15:0] n_kp, n_ki, n_kd;
    logic signed [32:0] n_opa, n_opb;
    logic signed [65:0] n_prod;

    always_comb begin
        n_ax  = i_cmd.axis;
        n_kp  = r_gains[n_ax][47:32];
        n_ki  = r_gains[n_ax][31:16];
        n_kd  = r_gains[n_ax][15:0];
        n_opa = '0;
        n_opb = '0;
        unique case (i_cmd.mul_sel)
            MUL_ERR_DT: begin
                n_opa = 33'(r_err[n_ax]);
                n_opb = {9'b0, r_dt};
            end
            MUL_KP: begin
                n_opa = 33'(n_kp);
                n_opb = 33'(r_err[n_ax]);
            end
            MUL_KI_LO: begin
                n_opa = 33'(n_ki);
                n_opb = {9'b0, r_accum[n_ax][23:0]};
            end
            MUL_KI_HI: begin
                n_opa = 33'(n_ki);
                n_opb = 33'($signed(r_accum[n_ax][47:24]));
            end
            MUL_KD_LO: begin
                n_opa = 33'(n_kd);
                n_opb = {9'b0, r_deriv[n_ax][23:0]};
            end
            MUL_KD_HI: begin
                n_opa = 33'(n_kd);
                n_opb = 33'($signed(r_deriv[n_ax][47:24]));
            end
            MUL_VX_C: begin
                n_opa = 33'(r_vel[0]);
                n_opb = n_cos;
            end
            MUL_VY_S: begin
                n_opa = 33'(r_vel[1]);
                n_opb = n_sin;
            end
            MUL_VY_C: begin
                n_opa = 33'(r_vel[1]);
                n_opb = n_cos;
            end
            MUL_VX_S: begin
                n_opa = 33'(r_vel[0]);
                n_opb = n_sin;
            end
            default: begin
                n_opa = '0;
                n_opb = '0;
            end
        endcase
        n_prod = n_opa * n_opb;
    end

    // Gain registers, integrators and last errors.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_gains[k] <= GAIN_RESET;
                r_last[k]  <= '0;
                r_accum[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GAINS_X:       r_gains[0] <= i_cfg_data;
                    REG_GAINS_Y:       r_gains[1] <= i_cfg_data;
                    REG_GAINS_HEADING: r_gains[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.div_end) begin
                for (int k = 0; k < 3; k++) r_last[k] <= r_err[k];
            end
            if (i_cmd.acc_op == ACC_INTEG) begin
                r_accum[n_ax] <= sat48(66'(r_accum[n_ax]) + (r_prod >>> 16));
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        // Item capture.
        if (i_cmd.load) begin
            r_err[0] <= sat32(66'(n_dx));
            r_err[1] <= sat32(66'(n_dy));
            r_err[2] <= 32'(n_eh);
            r_dt     <= i_time_step;
            r_x      <= CORDIC_K;
            r_y      <= '0;
            r_z      <= n_z0;
            r_flip   <= n_flip0;
        end
        // Divider lanes.
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.div_start) begin
                r_neg[k] <= n_diff[k][32];
                r_quo[k] <= {n_mag[k][32:0], 16'b0};
                r_rem[k] <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[k] <= n_qbit[k] ? 24'(n_rsh[k] - {1'b0, r_dt}) : n_rsh[k][23:0];
                r_quo[k] <= {r_quo[k][47:0], n_qbit[k]};
            end
            if (i_cmd.div_end) r_deriv[k] <= n_dres[k];
        end
        // CORDIC rotation step.
        if (i_cmd.cordic_step) begin
            if (!r_z[19]) begin
                r_x <= r_x - n_sy;
                r_y <= r_y + n_sx;
                r_z <= r_z - n_atan;
            end else begin
                r_x <= r_x + n_sy;
                r_y <= r_y - n_sx;
                r_z <= r_z + n_atan;
            end
        end
        // Shared multiplier.
        if (i_cmd.mul_sel != MUL_NONE) r_prod <= n_prod;
        // Product accumulation.
        unique case (i_cmd.acc_op)
            ACC_SUM_FIRST:   r_sum <= r_prod >>> 12;
            ACC_PART_SET:    r_part <= r_prod;
            ACC_PART_ADD_HI: r_part <= r_part + (r_prod <<< 24);
            ACC_SUM_NEXT:    r_sum <= r_sum + (r_part >>> 12);
            ACC_VEL_SET:     r_vel[n_ax] <= sat32(r_sum);
            ACC_PART_ADD:    r_part <= r_part + r_prod;
            ACC_PART_SUB:    r_part <= r_part - r_prod;
            ACC_FWD_SET:     r_fwd <= sat32(r_part >>> 30);
            ACC_LAT_SET:     r_lat <= sat32(r_part >>> 30);
            default: ;
        endcase
        // Output register.
        if (i_cmd.out_load) begin
            r_o_fwd  <= r_fwd;
            r_o_lat  <= r_lat;
            r_o_turn <= (r_vel[2] == 32'sh8000_0000) ? 32'sh7fff_ffff : -r_vel[2];
        end
    end

    assign o_vel_forward = r_o_fwd;
    assign o_vel_lateral = r_o_lat;
    assign o_turn_rate   = r_o_turn;

endmodule

// ===== hdl/ppr_ctrl.sv =====
// Sequencer of the pose controller: runs divide, CORDIC, PID and rotation
// phases and drives the handshakes. Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_ctrl
    import ppr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DIV,
        ST_DEND,
        ST_MAC,
        ST_ROT,
        ST_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;
    logic       r_out_valid, n_out_valid;
    logic       n_out_free;

    assign n_out_free = !r_out_valid || !i_out_stall;

    // Commands and next state.
    always_comb begin
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_cmd.cordic_idx = r_cnt[4:0];
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DSTART;
                end
            end
            ST_DSTART: begin
                // A zero time step ends the tick without a result.
                if (i_status.dt_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                // CORDIC runs alongside the first divider steps.
                o_cmd.div_step    = 1'b1;
                o_cmd.cordic_step = (r_cnt < 6'(CORDIC_ITERS));
                n_cnt             = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = ST_DEND;
            end
            ST_DEND: begin
                o_cmd.div_end = 1'b1;
                n_cnt         = '0;
                n_axis        = '0;
                n_state       = ST_MAC;
            end
            ST_MAC: begin
                // Per axis: integrate, then kp, ki and kd terms.
                unique case (r_cnt)
                    6'd0: o_cmd.mul_sel = MUL_ERR_DT;
                    6'd1: begin
                        o_cmd.acc_op  = ACC_INTEG;
                        o_cmd.mul_sel = MUL_KP;
                    end
                    6'd2: begin
                        o_cmd.acc_op  = ACC_SUM_FIRST;
                        o_cmd.mul_sel = MUL_KI_LO;
                    end
                    6'd3: begin
                        o_cmd.acc_op  = ACC_PART_SET;
                        o_cmd.mul_sel = MUL_KI_HI;
                    end
                    6'd4: begin
                        o_cmd.acc_op  = ACC_PART_ADD_HI;
                        o_cmd.mul_sel = MUL_KD_LO;
                    end
                    6'd5: o_cmd.acc_op = ACC_SUM_NEXT;
                    6'd6: begin
                        o_cmd.acc_op  = ACC_PART_SET;
                        o_cmd.mul_sel = MUL_KD_HI;
                    end
                    6'd7: o_cmd.acc_op = ACC_PART_ADD_HI;
                    6'd8: o_cmd.acc_op = ACC_SUM_NEXT;
                    default: o_cmd.acc_op = ACC_VEL_SET;
                endcase
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(MAC_STEPS - 1)) begin
                    n_cnt = '0;
                    if (r_axis == REG_GAINS_HEADING) n_state = ST_ROT;
                    else n_axis = r_axis + 2'd1;
                end
            end
            ST_ROT: begin
                // Rotate the global velocity into the robot frame.
                unique case (r_cnt)
                    6'd0: o_cmd.mul_sel = MUL_VX_C;
                    6'd1: begin
                        o_cmd.acc_op  = ACC_PART_SET;
                        o_cmd.mul_sel = MUL_VY_S;
                    end
                    6'd2: begin
                        o_cmd.acc_op  = ACC_PART_ADD;
                        o_cmd.mul_sel = MUL_VY_C;
                    end
                    6'd3: o_cmd.acc_op = ACC_FWD_SET;
                    6'd4: begin
                        o_cmd.acc_op  = ACC_PART_SET;
                        o_cmd.mul_sel = MUL_VX_S;
                    end
                    6'd5: o_cmd.acc_op = ACC_PART_SUB;
                    default: o_cmd.acc_op = ACC_LAT_SET;
                endcase
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(ROT_STEPS - 1)) n_state = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register is free.
                if (n_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/pose_pid_with_frame_rotation.sv =====
// Top level of the three-axis pose PID controller with body-frame rotation.
// Depends on ppr_pkg, ppr_ctrl, ppr_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "pose_pid_with_frame_rotation_defines.svh"

// One accepted input beat is one control tick. The block takes one tick at a
// time: a tick with a nonzero time step runs a load step, a setup step, the
// bit-serial divider steps (the CORDIC runs during the first of them), a step
// to close the division, the PID multiply-accumulate steps on one shared
// multiplier and the rotation steps, then leaves the result in the output
// register once that register is free. A tick with a zero time step ends
// after the setup step and yields no output beat. The next tick is accepted
// while a finished result still waits to be taken. Gain registers are
// written through the configuration channel, which is always ready.
module pose_pid_with_frame_rotation
    import ppr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_current_x,
    input  logic signed [31:0]  i_current_y,
    input  logic signed [18:0]  i_current_heading,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [18:0]  i_target_heading,
    input  logic        [23:0]  i_time_step,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_vel_forward,
    output logic signed [31:0]  o_vel_lateral,
    output logic signed [31:0]  o_turn_rate,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic        [1:0]   i_cfg_index,
    input  logic        [47:0]  i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    ppr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state.
    ppr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_current_x       (i_current_x),
        .i_current_y       (i_current_y),
        .i_current_heading (i_current_heading),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_target_heading  (i_target_heading),
        .i_time_step       (i_time_step),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_vel_forward     (o_vel_forward),
        .o_vel_lateral     (o_vel_lateral),
        .o_turn_rate       (o_turn_rate)
    );

    // An accepted tick keeps the block busy and cannot produce a beat at once.
    `PPR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall && !$rose(o_out_valid))
    // A new result appears only at the end of work, while input was stalled.
    `PPR_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule
